[hw/rtl/spfq_pkg.sv]
package spfq_pkg;

    localparam int NUM_LEVELS    = 8;
    localparam int LEVEL_DEPTH   = 16;
    localparam int PAYLOAD_WIDTH = 32;

    localparam int LVL_W    = $clog2(NUM_LEVELS);
    localparam int PTR_W    = $clog2(LEVEL_DEPTH);
    localparam int CNT_W    = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W   = $clog2(NUM_LEVELS * LEVEL_DEPTH);
    localparam int PRIO_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    typedef struct packed {
        logic                     is_pop;
        logic [LVL_W-1:0]         level;
        logic [PAYLOAD_WIDTH-1:0] data;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic                     pop_valid;
        logic [PAYLOAD_WIDTH-1:0] data;
        logic [LVL_W-1:0]         level;
        logic                     queue_empty;
    } rsp_t;

    typedef struct packed {
        logic                     we;
        logic                     re;
        logic [ADDR_W-1:0]        addr;
        logic [PAYLOAD_WIDTH-1:0] wdata;
    } mem_req_t;

endpackage

[hw/rtl/spfq_if.sv]
interface spfq_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [spfq_pkg::PRIO_W-1:0]  priority_req;
    logic [spfq_pkg::WORD_W-1:0]  payload;

    modport source (output valid, req_type, priority_req, payload, input ready);
    modport sink   (input valid, req_type, priority_req, payload, output ready);
endinterface

interface spfq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [spfq_pkg::STATUS_W-1:0] status;
    logic                          pop_valid;
    logic [spfq_pkg::WORD_W-1:0]   out_payload;
    logic [spfq_pkg::PRIO_W-1:0]   out_priority;
    logic                          queue_empty;

    modport source (output valid, status, pop_valid, out_payload, out_priority, queue_empty,
                    input ready);
    modport sink   (input valid, status, pop_valid, out_payload, out_priority, queue_empty,
                    output ready);
endinterface

[hw/rtl/spfq_ram.sv]
module spfq_ram (
    input  logic                                    clk,
    input  spfq_pkg::mem_req_t                      mem_req,
    output logic [spfq_pkg::PAYLOAD_WIDTH-1:0]      rdata
);

    logic [spfq_pkg::PAYLOAD_WIDTH-1:0] mem [spfq_pkg::NUM_LEVELS * spfq_pkg::LEVEL_DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.addr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rdata <= mem[mem_req.addr];
        end
    end

endmodule

[hw/rtl/spfq_ctrl.sv]
module spfq_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  spfq_pkg::req_t                      req,
    output logic                                out_valid,
    input  logic                                out_ready,
    output spfq_pkg::rsp_t                      rsp,
    output spfq_pkg::mem_req_t                  mem_req,
    input  logic [spfq_pkg::PAYLOAD_WIDTH-1:0]  rdata
);

    localparam int NL = spfq_pkg::NUM_LEVELS;
    localparam int LD = spfq_pkg::LEVEL_DEPTH;

    spfq_pkg::state_t state_reg, state_next;

    logic [spfq_pkg::CNT_W-1:0] cnt_reg  [NL];
    logic [spfq_pkg::CNT_W-1:0] cnt_next [NL];
    logic [spfq_pkg::PTR_W-1:0] head_reg  [NL];
    logic [spfq_pkg::PTR_W-1:0] head_next [NL];

    logic           out_valid_reg, out_valid_next;
    spfq_pkg::rsp_t rsp_reg, rsp_next;
    logic [spfq_pkg::LVL_W-1:0] pend_level_reg, pend_level_next;
    logic           pend_empty_reg, pend_empty_next;

    logic                         accept;
    logic [NL-1:0]                nz;
    logic                         found;
    logic [spfq_pkg::LVL_W-1:0]   top_lv;
    logic [spfq_pkg::LVL_W-1:0]   sel_lv;
    logic [spfq_pkg::CNT_W-1:0]   sel_cnt;
    logic [spfq_pkg::PTR_W-1:0]   sel_head;
    logic                         full;
    logic [spfq_pkg::PTR_W:0]     tail_sum;
    logic [spfq_pkg::PTR_W-1:0]   tail;
    logic [spfq_pkg::PTR_W-1:0]   head_inc;
    logic [NL-1:0]                others;
    logic                         empty_after_pop;

    always_comb
    begin
        nz     = '0;
        found  = 1'b0;
        top_lv = '0;
        for (int i = 0; i < NL; i++)
        begin
            nz[i] = (cnt_reg[i] != '0);
            if (nz[i])
            begin
                found  = 1'b1;
                top_lv = spfq_pkg::LVL_W'(i);
            end
        end
    end

    always_comb
    begin
        sel_lv   = req.is_pop ? top_lv : req.level;
        sel_cnt  = cnt_reg[sel_lv];
        sel_head = head_reg[sel_lv];
        full     = (sel_cnt == spfq_pkg::CNT_W'(LD));
        tail_sum = (spfq_pkg::PTR_W + 1)'(sel_head) + (spfq_pkg::PTR_W + 1)'(sel_cnt);
        if (tail_sum >= (spfq_pkg::PTR_W + 1)'(LD))
        begin
            tail = spfq_pkg::PTR_W'(tail_sum - (spfq_pkg::PTR_W + 1)'(LD));
        end
        else
        begin
            tail = tail_sum[spfq_pkg::PTR_W-1:0];
        end
        head_inc = (sel_head == spfq_pkg::PTR_W'(LD - 1)) ? '0 : sel_head + 1'b1;
        others   = nz & ~(NL'(1) << top_lv);
        empty_after_pop = (others == '0) && (sel_cnt == spfq_pkg::CNT_W'(1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spfq_pkg::S_IDLE:
            begin
                if (accept && req.is_pop && found)
                begin
                    state_next = spfq_pkg::S_READ;
                end
            end
            spfq_pkg::S_READ:
            begin
                state_next = spfq_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = (state_reg == spfq_pkg::S_IDLE) && (!out_valid_reg || out_ready);
        accept   = in_valid && in_ready;

        mem_req.we    = accept && !req.is_pop && !full;
        mem_req.re    = accept && req.is_pop && found;
        mem_req.addr  = spfq_pkg::ADDR_W'(sel_lv) * spfq_pkg::ADDR_W'(LD)
                      + spfq_pkg::ADDR_W'(req.is_pop ? sel_head : tail);
        mem_req.wdata = req.data;

        out_valid = out_valid_reg;
        rsp       = rsp_reg;
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        head_next       = head_reg;
        rsp_next        = rsp_reg;
        pend_level_next = pend_level_reg;
        pend_empty_next = pend_empty_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (accept)
        begin
            if (!req.is_pop)
            begin
                if (!full)
                begin
                    cnt_next[sel_lv] = sel_cnt + 1'b1;
                end
                rsp_next.status      = full ? spfq_pkg::STAT_FULL : spfq_pkg::STAT_OK;
                rsp_next.pop_valid   = 1'b0;
                rsp_next.data        = '0;
                rsp_next.level       = '0;
                rsp_next.queue_empty = 1'b0;
                out_valid_next       = 1'b1;
            end
            else if (found)
            begin
                cnt_next[sel_lv]  = sel_cnt - 1'b1;
                head_next[sel_lv] = head_inc;
                pend_level_next   = sel_lv;
                pend_empty_next   = empty_after_pop;
            end
            else
            begin
                rsp_next.status      = spfq_pkg::STAT_EMPTY;
                rsp_next.pop_valid   = 1'b0;
                rsp_next.data        = '0;
                rsp_next.level       = '0;
                rsp_next.queue_empty = 1'b1;
                out_valid_next       = 1'b1;
            end
        end

        if (state_reg == spfq_pkg::S_READ)
        begin
            rsp_next.status      = spfq_pkg::STAT_OK;
            rsp_next.pop_valid   = 1'b1;
            rsp_next.data        = rdata;
            rsp_next.level       = pend_level_reg;
            rsp_next.queue_empty = pend_empty_reg;
            out_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spfq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NL; i++)
            begin
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg        <= rsp_next;
        pend_level_reg <= pend_level_next;
        pend_empty_reg <= pend_empty_next;
    end

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spfq_pkg::S_READ) |-> !out_valid_reg)
        else $error("result slot busy while pop data returns");

    a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spfq_pkg::S_READ) |=> (out_valid_reg && rsp_reg.pop_valid))
        else $error("pop read did not produce a result");

    a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.is_pop && found) |=> (state_reg == spfq_pkg::S_READ))
        else $error("pop of a held entry did not start a read");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re))
        else $error("write and read issued together");

endmodule

[hw/rtl/strict_priority_fifo_queue.sv]
// Channel | Dir | Beat
// req     | in  | req_type, priority_req, payload
// rsp     | out | status, pop_valid, out_payload, out_priority, queue_empty
//
// A push result is loaded into the output register on acceptance; a pop of a
// held entry first reads the registered entry memory, then loads its data.
// One request is in flight at a time; req.ready drops while a pop read is
// outstanding or a result waits in the output register without rsp.ready.
// Reset clears the per-level head and count registers at once; the entry
// memory is not cleared and needs no clearing pass.
module strict_priority_fifo_queue (
    input  logic        clk,
    input  logic        rst_n,
    spfq_req_if.sink    req,
    spfq_rsp_if.source  rsp
);

    localparam int LW = spfq_pkg::LVL_W;
    localparam int PW = spfq_pkg::PAYLOAD_WIDTH;
    localparam int WW = spfq_pkg::WORD_W;

    spfq_pkg::req_t     core_req;
    spfq_pkg::rsp_t     core_rsp;
    spfq_pkg::mem_req_t mem_req;
    logic [PW-1:0]      rdata;

    logic [LW+2:0]      prio_ext;
    logic [LW+2:0]      lvl_out_ext;
    logic [PW+WW-1:0]   pay_in_ext;
    logic [PW+WW-1:0]   pay_out_ext;

    // saturate level, trim payload to stored width
    always_comb
    begin
        prio_ext = (LW + 3)'(req.priority_req);
        core_req.is_pop = req.req_type;
        if (prio_ext >= (LW + 3)'(spfq_pkg::NUM_LEVELS))
        begin
            core_req.level = LW'(spfq_pkg::NUM_LEVELS - 1);
        end
        else
        begin
            core_req.level = prio_ext[LW-1:0];
        end
        pay_in_ext    = {PW'(0), req.payload};
        core_req.data = pay_in_ext[PW-1:0];
    end

    always_comb
    begin
        lvl_out_ext       = (LW + 3)'(core_rsp.level);
        pay_out_ext       = {WW'(0), core_rsp.data};
        rsp.status        = core_rsp.status;
        rsp.pop_valid     = core_rsp.pop_valid;
        rsp.out_payload   = pay_out_ext[WW-1:0];
        rsp.out_priority  = lvl_out_ext[2:0];
        rsp.queue_empty   = core_rsp.queue_empty;
    end

    spfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .req       (core_req),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .rsp       (core_rsp),
        .mem_req   (mem_req),
        .rdata     (rdata)
    );

    spfq_ram u_ram (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

endmodule
